// File: rtl/lcg_pkg.sv
// ----------------------------------------------------------------------------
// lcg_pkg: shared constants and types for the 3D LUT color grading block
// Widths, register indexes and channel codes used by the interfaces and the
// grading pipeline.
// ----------------------------------------------------------------------------
package lcg_pkg;

   // Largest supported points per axis of the cube.
   localparam int MAX_GRID   = 33;
   localparam int CUBE_DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
   localparam int ADDR_W     = $clog2(CUBE_DEPTH);

   // Grid size value (0..MAX_GRID) and per-axis lattice index (0..MAX_GRID-1).
   localparam int GRID_W = $clog2(MAX_GRID + 1);
   localparam int IDX_W  = $clog2(MAX_GRID);

   // Fixed field widths of the words.
   localparam int PIX_W      = 8;
   localparam int ENTRY_W    = 13;
   localparam int INDEX_W    = 16;
   localparam int LANES      = 3;
   localparam int CHAN_MAX   = 255;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SIZE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CUBE_ENABLE = CSR_IDX_W'(1);

   // Input word action codes.
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   typedef logic [PIX_W-1:0]   pix_type;
   typedef logic [ENTRY_W-1:0] entry_type;

   typedef struct packed {
      entry_type red;
      entry_type green;
      entry_type blue;
   } cube_word_type;

endpackage

// File: rtl/lcg_req_if.sv
// ----------------------------------------------------------------------------
// lcg_req_if: input channel of the color grading block
// Carries either a cube entry write or a pixel to grade, with valid/ready.
// ----------------------------------------------------------------------------
interface lcg_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [lcg_pkg::INDEX_W-1:0]   entry_index;
   logic [lcg_pkg::ENTRY_W-1:0]   entry_red;
   logic [lcg_pkg::ENTRY_W-1:0]   entry_green;
   logic [lcg_pkg::ENTRY_W-1:0]   entry_blue;
   logic [lcg_pkg::PIX_W-1:0]     pixel_red;
   logic [lcg_pkg::PIX_W-1:0]     pixel_green;
   logic [lcg_pkg::PIX_W-1:0]     pixel_blue;

   modport source (
      output valid, action, entry_index, entry_red, entry_green, entry_blue,
             pixel_red, pixel_green, pixel_blue,
      input  ready
   );

   modport sink (
      input  valid, action, entry_index, entry_red, entry_green, entry_blue,
             pixel_red, pixel_green, pixel_blue,
      output ready
   );
endinterface

// File: rtl/lcg_rsp_if.sv
// ----------------------------------------------------------------------------
// lcg_rsp_if: result channel of the color grading block
// Carries one graded pixel per word, with valid/ready.
// ----------------------------------------------------------------------------
interface lcg_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lcg_pkg::PIX_W-1:0] out_red;
   logic [lcg_pkg::PIX_W-1:0] out_green;
   logic [lcg_pkg::PIX_W-1:0] out_blue;

   modport source (
      output valid, out_red, out_green, out_blue,
      input  ready
   );

   modport sink (
      input  valid, out_red, out_green, out_blue,
      output ready
   );
endinterface

// File: rtl/lcg_csr_if.sv
// ----------------------------------------------------------------------------
// lcg_csr_if: configuration write channel of the color grading block
// Carries a register index and write data, with valid/ready.
// ----------------------------------------------------------------------------
interface lcg_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lcg_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [lcg_pkg::CSR_DATA_W-1:0] write_data;

   modport source (
      output valid, reg_index, write_data,
      input  ready
   );

   modport sink (
      input  valid, reg_index, write_data,
      output ready
   );
endinterface

// File: rtl/lut3d_color_grade_top.sv
// ----------------------------------------------------------------------------
// lut3d_color_grade_top: color grading through a stored 3D lookup cube
// Pixel words are graded by a two-corner diagonal blend of cube entries held
// in an on-chip dual-read memory; write words load cube entries.
// ----------------------------------------------------------------------------
// Usage:
// The req_bus channel takes one word per clock when not stalled. A word with
// action ACT_WRITE stores three Q1.12 values at entry_index (indexes at or
// above the cube depth are dropped) and produces no result. A word with
// action ACT_PIXEL produces exactly one rsp_bus word, in order. Pixels pass
// through unchanged while cube_enable is 0 or grid_size is 0.
// The csr_bus channel is always ready; the user must see that it is written
// only while the block is idle, which the block does not enforce. grid_size
// above MAX_GRID acts as MAX_GRID.
// Throughput is one word per clock when not stalled: the cube memory has two
// read ports, so the floor and ceil corners are fetched in the same cycle.
// Writes and reads of the cube happen in the same pipeline stage, so a pixel
// always sees every write accepted ahead of it.
// Reset (synchronous, active high) empties the pipeline and clears both
// configuration registers. The cube memory is not cleared; an entry must be
// written before a pixel uses it.
// When rsp_bus stalls, each stage holds its word only if the stage after it is
// full, so words keep entering until the pipeline bubbles are used up.
// ----------------------------------------------------------------------------
module lut3d_color_grade_top (
   input  logic        clock,
   input  logic        reset,
   lcg_req_if.sink     req_bus,
   lcg_rsp_if.source   rsp_bus,
   lcg_csr_if.sink     csr_bus
);

   localparam int LANES   = lcg_pkg::LANES;
   localparam int PROD_W  = lcg_pkg::PIX_W + lcg_pkg::GRID_W;
   localparam int QEST_W  = PROD_W - 7;
   localparam int REM_W   = 8;
   localparam int GN_W    = lcg_pkg::IDX_W + lcg_pkg::GRID_W;
   localparam int BN_W    = lcg_pkg::IDX_W + 2 * lcg_pkg::GRID_W;
   localparam int SUM_W   = BN_W + 1;
   localparam int BLEND_W = REM_W + lcg_pkg::ENTRY_W;
   localparam int ACC_W   = BLEND_W + 1;
   localparam int QUO_W   = ACC_W - 12;

   // Configuration registers, kept as the effective grid size and its square.
   logic                            enable_ff;
   logic [lcg_pkg::GRID_W-1:0]      grid_n_ff, grid_n_in;
   logic [2*lcg_pkg::GRID_W-1:0]    grid_nn_ff, grid_nn_in;

   // Stage valids and load enables.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

   // Payload carried by write words through stage 4.
   logic                            pix1_ff, pix2_ff, pix3_ff, pix4_ff;
   logic                            inrange1_ff, inrange2_ff, inrange3_ff, inrange4_ff;
   logic [lcg_pkg::INDEX_W-1:0]     widx1_ff, widx2_ff, widx3_ff, widx4_ff;
   lcg_pkg::cube_word_type          wdata1_ff, wdata2_ff, wdata3_ff, wdata4_ff;

   // Pixel payload.
   logic                            byp1_ff, byp2_ff, byp3_ff, byp4_ff, byp5_ff, byp6_ff;
   lcg_pkg::pix_type                px1_ff [LANES];
   lcg_pkg::pix_type                px2_ff [LANES];
   lcg_pkg::pix_type                px3_ff [LANES];
   lcg_pkg::pix_type                px4_ff [LANES];
   lcg_pkg::pix_type                px5_ff [LANES];
   lcg_pkg::pix_type                px6_ff [LANES];
   logic [PROD_W-1:0]               prod1_ff [LANES];
   logic [PROD_W-1:0]               prod1_in [LANES];
   logic [lcg_pkg::GRID_W-1:0]      grid_nm1;

   // Divide-by-255 stage.
   logic [PROD_W:0]                 est_sum [LANES];
   logic [QEST_W-1:0]               q_est [LANES];
   logic [PROD_W:0]                 r_est [LANES];
   logic [lcg_pkg::IDX_W-1:0]       qlo2_in [LANES];
   logic [lcg_pkg::IDX_W-1:0]       qhi2_in [LANES];
   logic [REM_W-1:0]                m2_in [LANES];
   logic [lcg_pkg::IDX_W-1:0]       qlo2_ff [LANES];
   logic [lcg_pkg::IDX_W-1:0]       qhi2_ff [LANES];
   logic [REM_W-1:0]                m2_ff [LANES];
   logic [REM_W-1:0]                m3_ff [LANES];
   logic [REM_W-1:0]                m4_ff [LANES];
   logic [REM_W-1:0]                m5_ff [LANES];

   // Address partial products.
   logic [lcg_pkg::IDX_W-1:0]       rlo3_ff, rhi3_ff;
   logic [GN_W-1:0]                 glo3_ff, ghi3_ff;
   logic [BN_W-1:0]                 blo3_ff, bhi3_ff;
   logic [SUM_W-1:0]                sum_lo, sum_hi;
   logic [lcg_pkg::ADDR_W-1:0]      addr_lo, addr_hi;
   logic [lcg_pkg::ADDR_W-1:0]      addr_lo4_ff, addr_hi4_ff;

   // Cube memory and its registered read data.
   lcg_pkg::cube_word_type          cube_mem [lcg_pkg::CUBE_DEPTH];
   lcg_pkg::cube_word_type          lo_rd_ff, hi_rd_ff;
   logic                            mem_we;
   lcg_pkg::entry_type              lo_ch [LANES];
   lcg_pkg::entry_type              hi_ch [LANES];

   // Blend stages.
   logic [BLEND_W-1:0]              lo_prod_ff [LANES];
   logic [BLEND_W-1:0]              hi_prod_ff [LANES];
   logic [ACC_W-1:0]                acc [LANES];
   logic [QUO_W-1:0]                quo [LANES];
   lcg_pkg::pix_type                out_in [LANES];
   lcg_pkg::pix_type                out_ff [LANES];

   // -------------------------------------------------------------------------
   // Configuration port. Always ready; the grid size is clamped on write and
   // its square is kept alongside for the address arithmetic.
   // -------------------------------------------------------------------------
   assign csr_bus.ready = 1'b1;

   always_comb begin
      if (32'(csr_bus.write_data) > lcg_pkg::MAX_GRID) begin
         grid_n_in = lcg_pkg::GRID_W'(lcg_pkg::MAX_GRID);
      end else begin
         grid_n_in = lcg_pkg::GRID_W'(csr_bus.write_data);
      end
      grid_nn_in = (2*lcg_pkg::GRID_W)'(grid_n_in) * (2*lcg_pkg::GRID_W)'(grid_n_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         grid_n_ff  <= '0;
         grid_nn_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            lcg_pkg::CSR_GRID_SIZE: begin
               grid_n_ff  <= grid_n_in;
               grid_nn_ff <= grid_nn_in;
            end
            lcg_pkg::CSR_CUBE_ENABLE: begin
               enable_ff <= csr_bus.write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Pipeline flow control. A stage loads when it is empty or the stage after
   // it is loading too. Write words leave the pipeline after stage 4.
   // -------------------------------------------------------------------------
   assign adv7 = !v7_ff || rsp_bus.ready;
   assign adv6 = !v6_ff || adv7;
   assign adv5 = !v5_ff || adv6;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_bus.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_bus.valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff && pix4_ff;
         if (adv6) v6_ff <= v5_ff;
         if (adv7) v7_ff <= v6_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 1: capture the word and form c*(N-1) for each channel.
   // -------------------------------------------------------------------------
   assign grid_nm1 = grid_n_ff - lcg_pkg::GRID_W'(1);

   always_comb begin
      prod1_in[0] = PROD_W'(req_bus.pixel_red)   * PROD_W'(grid_nm1);
      prod1_in[1] = PROD_W'(req_bus.pixel_green) * PROD_W'(grid_nm1);
      prod1_in[2] = PROD_W'(req_bus.pixel_blue)  * PROD_W'(grid_nm1);
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         pix1_ff         <= (req_bus.action == lcg_pkg::ACT_PIXEL);
         inrange1_ff     <= (32'(req_bus.entry_index) < lcg_pkg::CUBE_DEPTH);
         widx1_ff        <= req_bus.entry_index;
         wdata1_ff.red   <= req_bus.entry_red;
         wdata1_ff.green <= req_bus.entry_green;
         wdata1_ff.blue  <= req_bus.entry_blue;
         byp1_ff         <= !enable_ff || (grid_n_ff == '0);
         px1_ff[0]       <= req_bus.pixel_red;
         px1_ff[1]       <= req_bus.pixel_green;
         px1_ff[2]       <= req_bus.pixel_blue;
         prod1_ff        <= prod1_in;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 2: split each product by 255 into a floor index and a remainder.
   // The estimate (x + x/256)/256 is low by at most one, so a single
   // compare and subtract finishes the division.
   // -------------------------------------------------------------------------
   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         est_sum[c] = {1'b0, prod1_ff[c]} + (PROD_W+1)'(prod1_ff[c] >> 8);
         q_est[c]   = est_sum[c][PROD_W:8];
         r_est[c]   = (PROD_W+1)'(prod1_ff[c]) + (PROD_W+1)'(q_est[c])
                      - ((PROD_W+1)'(q_est[c]) << 8);
         if (r_est[c] >= (PROD_W+1)'(lcg_pkg::CHAN_MAX)) begin
            qlo2_in[c] = lcg_pkg::IDX_W'(q_est[c] + QEST_W'(1));
            m2_in[c]   = REM_W'(r_est[c] - (PROD_W+1)'(lcg_pkg::CHAN_MAX));
         end else begin
            qlo2_in[c] = lcg_pkg::IDX_W'(q_est[c]);
            m2_in[c]   = REM_W'(r_est[c]);
         end
         qhi2_in[c] = qlo2_in[c] + lcg_pkg::IDX_W'(m2_in[c] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         pix2_ff     <= pix1_ff;
         inrange2_ff <= inrange1_ff;
         widx2_ff    <= widx1_ff;
         wdata2_ff   <= wdata1_ff;
         byp2_ff     <= byp1_ff;
         px2_ff      <= px1_ff;
         qlo2_ff     <= qlo2_in;
         qhi2_ff     <= qhi2_in;
         m2_ff       <= m2_in;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 3: green and blue terms of both corner addresses.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv3) begin
         pix3_ff     <= pix2_ff;
         inrange3_ff <= inrange2_ff;
         widx3_ff    <= widx2_ff;
         wdata3_ff   <= wdata2_ff;
         byp3_ff     <= byp2_ff;
         px3_ff      <= px2_ff;
         m3_ff       <= m2_ff;
         rlo3_ff     <= qlo2_ff[0];
         rhi3_ff     <= qhi2_ff[0];
         glo3_ff     <= GN_W'(qlo2_ff[1]) * GN_W'(grid_n_ff);
         ghi3_ff     <= GN_W'(qhi2_ff[1]) * GN_W'(grid_n_ff);
         blo3_ff     <= BN_W'(qlo2_ff[2]) * BN_W'(grid_nn_ff);
         bhi3_ff     <= BN_W'(qhi2_ff[2]) * BN_W'(grid_nn_ff);
      end
   end

   // -------------------------------------------------------------------------
   // Stage 4: finish the corner addresses and access the cube. Reads and
   // writes share this stage, so program order is kept with no forwarding.
   // -------------------------------------------------------------------------
   always_comb begin
      sum_lo = SUM_W'(rlo3_ff) + SUM_W'(glo3_ff) + SUM_W'(blo3_ff);
      sum_hi = SUM_W'(rhi3_ff) + SUM_W'(ghi3_ff) + SUM_W'(bhi3_ff);
      if (32'(sum_lo) >= lcg_pkg::CUBE_DEPTH) begin
         addr_lo = lcg_pkg::ADDR_W'(lcg_pkg::CUBE_DEPTH - 1);
      end else begin
         addr_lo = lcg_pkg::ADDR_W'(sum_lo);
      end
      if (32'(sum_hi) >= lcg_pkg::CUBE_DEPTH) begin
         addr_hi = lcg_pkg::ADDR_W'(lcg_pkg::CUBE_DEPTH - 1);
      end else begin
         addr_hi = lcg_pkg::ADDR_W'(sum_hi);
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         pix4_ff     <= pix3_ff;
         inrange4_ff <= inrange3_ff;
         widx4_ff    <= widx3_ff;
         wdata4_ff   <= wdata3_ff;
         byp4_ff     <= byp3_ff;
         px4_ff      <= px3_ff;
         m4_ff       <= m3_ff;
         addr_lo4_ff <= addr_lo;
         addr_hi4_ff <= addr_hi;
      end
   end

   assign mem_we = adv5 && v4_ff && !pix4_ff && inrange4_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cube_mem[lcg_pkg::ADDR_W'(widx4_ff)] <= wdata4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         lo_rd_ff <= cube_mem[addr_lo4_ff];
         hi_rd_ff <= cube_mem[addr_hi4_ff];
         byp5_ff  <= byp4_ff;
         px5_ff   <= px4_ff;
         m5_ff    <= m4_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 6: weight both corners, (255-m)*L and m*H per channel.
   // -------------------------------------------------------------------------
   always_comb begin
      lo_ch[0] = lo_rd_ff.red;
      lo_ch[1] = lo_rd_ff.green;
      lo_ch[2] = lo_rd_ff.blue;
      hi_ch[0] = hi_rd_ff.red;
      hi_ch[1] = hi_rd_ff.green;
      hi_ch[2] = hi_rd_ff.blue;
   end

   always_ff @(posedge clock) begin
      if (adv6) begin
         byp6_ff <= byp5_ff;
         px6_ff  <= px5_ff;
         for (int c = 0; c < LANES; c++) begin
            lo_prod_ff[c] <= BLEND_W'(REM_W'(lcg_pkg::CHAN_MAX) - m5_ff[c])
                             * BLEND_W'(lo_ch[c]);
            hi_prod_ff[c] <= BLEND_W'(m5_ff[c]) * BLEND_W'(hi_ch[c]);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stage 7: sum, scale down from Q1.12, saturate, or pass the pixel through.
   // -------------------------------------------------------------------------
   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         acc[c] = ACC_W'(lo_prod_ff[c]) + ACC_W'(hi_prod_ff[c]);
         quo[c] = acc[c][ACC_W-1:12];
         if (byp6_ff) begin
            out_in[c] = px6_ff[c];
         end else if (quo[c] > QUO_W'(lcg_pkg::CHAN_MAX)) begin
            out_in[c] = lcg_pkg::PIX_W'(lcg_pkg::CHAN_MAX);
         end else begin
            out_in[c] = lcg_pkg::PIX_W'(quo[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv7) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid     = v7_ff;
   assign rsp_bus.out_red   = out_ff[0];
   assign rsp_bus.out_green = out_ff[1];
   assign rsp_bus.out_blue  = out_ff[2];

endmodule

// File: dv/lut3d_color_grade_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lut3d_color_grade_checker: result predictor and scoreboard
// Watches the request, result and register channels, keeps its own copy of
// the cube and the settings, grades each accepted pixel and compares every
// result word with the oldest graded pixel still waiting.
// ----------------------------------------------------------------------------
module lut3d_color_grade_checker
   import lcg_pkg::*;
(
   input  logic clock,
   input  logic reset,
   lcg_req_if   req_mon,
   lcg_rsp_if   rsp_mon,
   lcg_csr_if   csr_mon,
   output int   fail_count,
   output int   outstanding
);

   typedef struct packed {
      pix_type red;
      pix_type green;
      pix_type blue;
   } graded_pixel_type;

   localparam int REPORT_LIMIT = 10;

   cube_word_type     cube_copy [CUBE_DEPTH];
   logic [GRID_W-1:0] grid_reg;
   logic              enable_reg;
   graded_pixel_type  graded_q [$];
   int                failures = 0;

   // One lane of the diagonal blend, saturated to the 8-bit range.
   function automatic pix_type blend_lane(entry_type lo, entry_type hi,
                                          int unsigned rem);
      int unsigned mix;
      mix = ((CHAN_MAX - rem) * lo + rem * hi) >> 12;
      return (mix > CHAN_MAX) ? pix_type'(CHAN_MAX) : pix_type'(mix);
   endfunction

   function automatic graded_pixel_type grade_pixel(pix_type red, pix_type green,
                                                    pix_type blue);
      int unsigned      n, prod, stride, lo_addr, hi_addr;
      int unsigned      rem [LANES];
      pix_type          level [LANES];
      cube_word_type    lo_word, hi_word;
      graded_pixel_type result;
      result.red   = red;
      result.green = green;
      result.blue  = blue;
      n = (grid_reg > MAX_GRID) ? MAX_GRID : grid_reg;
      if (!enable_reg || n == 0) begin
         return result;
      end
      level   = '{red, green, blue};
      stride  = 1;
      lo_addr = 0;
      hi_addr = 0;
      for (int i = 0; i < LANES; i++) begin
         prod    = level[i] * (n - 1);
         rem[i]  = prod % CHAN_MAX;
         lo_addr = lo_addr + (prod / CHAN_MAX) * stride;
         hi_addr = hi_addr + (prod / CHAN_MAX + (rem[i] != 0)) * stride;
         stride  = stride * n;
      end
      if (lo_addr >= CUBE_DEPTH) lo_addr = CUBE_DEPTH - 1;
      if (hi_addr >= CUBE_DEPTH) hi_addr = CUBE_DEPTH - 1;
      lo_word = cube_copy[lo_addr];
      hi_word = cube_copy[hi_addr];
      result.red   = blend_lane(lo_word.red,   hi_word.red,   rem[0]);
      result.green = blend_lane(lo_word.green, hi_word.green, rem[1]);
      result.blue  = blend_lane(lo_word.blue,  hi_word.blue,  rem[2]);
      return result;
   endfunction

   always @(posedge clock) begin
      graded_pixel_type want;
      graded_pixel_type seen;
      if (reset) begin
         grid_reg    = '0;
         enable_reg  = 1'b0;
         graded_q.delete();
         outstanding <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.reg_index)
               CSR_GRID_SIZE:   grid_reg   = csr_mon.write_data[GRID_W-1:0];
               CSR_CUBE_ENABLE: enable_reg = csr_mon.write_data[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == ACT_WRITE) begin
               if (req_mon.entry_index < CUBE_DEPTH) begin
                  cube_copy[req_mon.entry_index] = '{req_mon.entry_red,
                                                     req_mon.entry_green,
                                                     req_mon.entry_blue};
               end
            end else begin
               graded_q.push_back(grade_pixel(req_mon.pixel_red,
                                              req_mon.pixel_green,
                                              req_mon.pixel_blue));
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = {rsp_mon.out_red, rsp_mon.out_green, rsp_mon.out_blue};
            if (graded_q.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("%0t: result word %0d/%0d/%0d with no pixel waiting",
                           $time, seen.red, seen.green, seen.blue);
               end
            end else begin
               want = graded_q.pop_front();
               if (seen !== want) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display("%0t: graded pixel expected %0d/%0d/%0d, got %0d/%0d/%0d",
                              $time, want.red, want.green, want.blue,
                              seen.red, seen.green, seen.blue);
                  end
               end
            end
         end
         outstanding <= graded_q.size();
      end
      fail_count <= failures;
   end

endmodule

// File: dv/lut3d_color_grade_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lut3d_color_grade_top_tb: testbench for the 3D LUT color grading block
// Loads cube entries and streams pixels through several grid sizes and enable
// settings under varied back-pressure; a side checker grades every pixel on
// its own and compares the result words.
// ----------------------------------------------------------------------------
module lut3d_color_grade_top_tb;
   import lcg_pkg::*;

   // Words counted toward the random part; writes that the block drops
   // because their index lies past the cube are not counted.
   localparam int RANDOM_WORDS = 1950;
   localparam int PHASES       = 8;
   // The margin lets the pipeline run empty; it covers a write that is still
   // in flight when the last graded word has come back.
   localparam int DRAIN_CYCLES = 12;
   localparam int RUN_LIMIT_NS = 5_000_000;
   localparam int ENTRY_ONE    = 4096;
   localparam int ENTRY_TOP    = 8191;

   logic clock = 1'b0;
   logic reset;

   // Chance per cycle, in percent, that the sender idles or the receiver
   // stalls. Both change only between phases.
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // Stimulus-side bookkeeping: which cube entries hold a value, and the
   // settings last written, so that no pixel ever reads an unwritten entry.
   bit                cube_loaded [CUBE_DEPTH];
   logic [GRID_W-1:0] grid_value   = '0;
   logic              enable_value = 1'b0;
   int                useful_words = 0;

   int fail_count;
   int outstanding;

   lcg_req_if req_bus ();
   lcg_rsp_if rsp_bus ();
   lcg_csr_if csr_bus ();

   lut3d_color_grade_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   lut3d_color_grade_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver decides afresh at every edge whether it takes a word.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // Entry values mostly stay at or below 1.0 in Q1.12; some use all 13 bits so
   // that the saturation of a graded channel gets exercised.
   function automatic entry_type rand_entry();
      case ($urandom_range(9))
         0:       return ($urandom_range(1)) ? entry_type'(ENTRY_TOP) : entry_type'(0);
         1:       return entry_type'(ENTRY_ONE);
         2, 3:    return entry_type'($urandom_range(ENTRY_TOP));
         default: return entry_type'($urandom_range(ENTRY_ONE));
      endcase
   endfunction

   // Pixel levels lean a little toward the ends of the range, where the
   // floor and ceil corners sit on the faces of the cube.
   function automatic pix_type rand_level();
      case ($urandom_range(9))
         0:       return pix_type'(0);
         1:       return pix_type'(CHAN_MAX);
         default: return pix_type'($urandom_range(CHAN_MAX));
      endcase
   endfunction

   // Presents one word and holds it until the block takes it. The sender may
   // idle first; valid is only ever raised or lowered once per edge.
   task automatic send_word(input logic action, input int unsigned index,
                            input entry_type e_red, input entry_type e_green,
                            input entry_type e_blue, input pix_type p_red,
                            input pix_type p_green, input pix_type p_blue);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= action;
      req_bus.entry_index <= INDEX_W'(index);
      req_bus.entry_red   <= e_red;
      req_bus.entry_green <= e_green;
      req_bus.entry_blue  <= e_blue;
      req_bus.pixel_red   <= p_red;
      req_bus.pixel_green <= p_green;
      req_bus.pixel_blue  <= p_blue;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // A cube write word. The pixel fields are don't-care here, so they carry
   // random bits.
   task automatic load_entry(input int unsigned index, input entry_type e_red,
                             input entry_type e_green, input entry_type e_blue);
      send_word(ACT_WRITE, index, e_red, e_green, e_blue,
                rand_level(), rand_level(), rand_level());
      if (index < CUBE_DEPTH) begin
         cube_loaded[index] = 1'b1;
         useful_words++;
      end
   endtask

   // A pixel word. When the cube is in use, the two corners that the pixel
   // will read are loaded first if they have never been written, which makes
   // the usual write-write-pixel sequence of a real loader.
   task automatic grade_word(input pix_type red, input pix_type green,
                             input pix_type blue);
      int unsigned n, prod, stride, lo_addr, hi_addr;
      pix_type     level [LANES];
      n = (grid_value > MAX_GRID) ? MAX_GRID : grid_value;
      if (enable_value && n != 0) begin
         level   = '{red, green, blue};
         stride  = 1;
         lo_addr = 0;
         hi_addr = 0;
         for (int i = 0; i < LANES; i++) begin
            prod    = level[i] * (n - 1);
            lo_addr = lo_addr + (prod / CHAN_MAX) * stride;
            hi_addr = hi_addr + (prod / CHAN_MAX + (prod % CHAN_MAX != 0)) * stride;
            stride  = stride * n;
         end
         if (!cube_loaded[lo_addr]) load_entry(lo_addr, rand_entry(), rand_entry(),
                                               rand_entry());
         if (!cube_loaded[hi_addr]) load_entry(hi_addr, rand_entry(), rand_entry(),
                                               rand_entry());
      end
      send_word(ACT_PIXEL, $urandom_range(16'hFFFF),
                entry_type'($urandom_range(ENTRY_TOP)),
                entry_type'($urandom_range(ENTRY_TOP)),
                entry_type'($urandom_range(ENTRY_TOP)), red, green, blue);
      useful_words++;
   endtask

   // Stops sending and waits until every graded pixel has come back, then
   // lets the pipeline run empty so no write word is left in flight.
   // The outstanding count is a registered copy, so the first look happens
   // after an edge to include the word accepted last.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid      <= 1'b1;
      csr_bus.reg_index  <= index;
      csr_bus.write_data <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   // Settings only change with the block idle. Both registers are written
   // each time, back to back, and valid drops after the second one.
   task automatic set_grading(input int grid, input logic enable);
      wait_drained();
      write_reg(CSR_GRID_SIZE, CSR_DATA_W'(grid));
      write_reg(CSR_CUBE_ENABLE, CSR_DATA_W'(enable));
      csr_bus.valid <= 1'b0;
      grid_value   = GRID_W'(grid);
      enable_value = enable;
   endtask

   initial begin
      int  phase_end;
      int  pick;
      int  grid;
      int  n;
      bit  paused;
      req_bus.valid       = 1'b0;
      req_bus.action      = ACT_WRITE;
      req_bus.entry_index = '0;
      req_bus.entry_red   = '0;
      req_bus.entry_green = '0;
      req_bus.entry_blue  = '0;
      req_bus.pixel_red   = '0;
      req_bus.pixel_green = '0;
      req_bus.pixel_blue  = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.reg_index   = '0;
      csr_bus.write_data  = '0;
      paused              = 1'b0;
      reset               = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Settings straight out of reset leave the cube off, so pixels pass
      // through untouched. Writes past the end of the cube must be dropped.
      grade_word(8'd0, 8'd0, 8'd0);
      grade_word(8'd255, 8'd255, 8'd255);
      grade_word(8'h5A, 8'hA5, 8'h3C);
      load_entry(CUBE_DEPTH, entry_type'(ENTRY_TOP), '0, entry_type'(ENTRY_ONE));
      load_entry(16'hFFFF, entry_type'(ENTRY_TOP), entry_type'(ENTRY_TOP),
                 entry_type'(ENTRY_TOP));

      // A two-point cube with corner values of 0 and 1.0 in Q1.12;
      // the far corner is over-range so the blend saturates.
      set_grading(2, 1'b1);
      for (int i = 0; i < 8; i++) begin
         if (i == 7) begin
            load_entry(i, entry_type'(ENTRY_TOP), entry_type'(ENTRY_TOP),
                       entry_type'(ENTRY_TOP));
         end else begin
            load_entry(i, (i & 1) ? entry_type'(ENTRY_ONE) : '0,
                          (i & 2) ? entry_type'(ENTRY_ONE) : '0,
                          (i & 4) ? entry_type'(ENTRY_ONE) : '0);
         end
      end
      grade_word(8'd0, 8'd0, 8'd0);
      grade_word(8'd255, 8'd255, 8'd255);
      grade_word(8'd254, 8'd254, 8'd254);
      grade_word(8'd255, 8'd0, 8'd0);
      grade_word(8'd1, 8'd128, 8'd200);

      // Enabled with a zero grid size still passes pixels through.
      set_grading(0, 1'b1);
      grade_word(8'd17, 8'd200, 8'd255);

      // A one-point cube reads entry zero for every pixel.
      set_grading(1, 1'b1);
      load_entry(0, entry_type'(ENTRY_ONE), entry_type'(2048), entry_type'(1));
      grade_word(8'd255, 8'd128, 8'd0);

      // A grid size past the largest one acts as the largest; the white
      // pixel reads the very last entry of the memory.
      set_grading(63, 1'b1);
      grade_word(8'd255, 8'd255, 8'd255);
      grade_word(8'd1, 8'd2, 8'd3);

      // The cube switched off at full size.
      set_grading(MAX_GRID, 1'b0);
      grade_word(8'd99, 8'd0, 8'd255);

      // Random phases. Each one picks a grid size and a back-pressure mode;
      // most words are pixels with their corners loaded, the rest rewrite
      // entries of the current cube or miss the memory altogether.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       grid = 2;
            1:       grid = 5;
            2:       grid = MAX_GRID;
            3:       grid = $urandom_range(63, 1);
            4:       grid = 0;
            5:       grid = 63;
            6:       grid = 3;
            default: grid = 17;
         endcase
         set_grading(grid, (p != 6));
         case (p % 4)
            0: begin
               send_idle_pct <= 0;
               stall_pct     <= 0;
            end
            1: begin
               send_idle_pct <= 56;
               stall_pct     <= 0;
            end
            2: begin
               send_idle_pct <= 0;
               stall_pct     <= 56;
            end
            default: begin
               send_idle_pct <= 16;
               stall_pct     <= 16;
            end
         endcase
         n = (grid > MAX_GRID) ? MAX_GRID : grid;
         phase_end = useful_words + RANDOM_WORDS / PHASES;
         while (useful_words < phase_end) begin
            // Once, halfway through the full-size phase, the sender holds off
            // until every pixel sent so far has been graded.
            if (p == 2 && !paused &&
                useful_words >= phase_end - RANDOM_WORDS / (2 * PHASES)) begin
               wait_drained();
               paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 65) begin
               grade_word(rand_level(), rand_level(), rand_level());
            end else if (pick < 92) begin
               load_entry((n > 0) ? $urandom_range(n * n * n - 1)
                                  : $urandom_range(CUBE_DEPTH - 1),
                          rand_entry(), rand_entry(), rand_entry());
            end else begin
               load_entry($urandom_range(16'hFFFF, CUBE_DEPTH),
                          rand_entry(), rand_entry(), rand_entry());
            end
         end
      end

      wait_drained();
      if (fail_count == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Hard stop in case the block hangs or loses words.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
rtl/lcg_pkg.sv
rtl/lcg_req_if.sv
rtl/lcg_rsp_if.sv
rtl/lcg_csr_if.sv
rtl/lut3d_color_grade_top.sv
dv/lut3d_color_grade_checker.sv
dv/lut3d_color_grade_top_tb.sv
